### src/bfa_pkg.sv
package bfa_pkg;

   // widest block count the size field is built for
   localparam int MAX_BLOCKS = 8;
   localparam int DEF_NUM_BLOCKS = 4;

   localparam int BASE_W = 16;
   // width of the largest block size: base shifted by the highest index
   localparam int SIZE_W = BASE_W + MAX_BLOCKS - 1;
   localparam int ID_W = 4;

   localparam logic [BASE_W-1:0] BASE_RESET = 16'd512;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   typedef enum logic [1:0] {
      ST_ALLOCATED = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FREED = 2'd2,
      ST_UNKNOWN = 2'd3
   } bfa_status_type;

   typedef struct packed {
      logic req_type;
      logic [SIZE_W-1:0] request_size;
      logic [ID_W-1:0] block_id;
   } bfa_req_type;

   typedef struct packed {
      bfa_status_type status;
      logic [ID_W-1:0] result_id;
   } bfa_rsp_type;

   // verdict of the shared fit unit on one block
   typedef struct packed {
      logic take;
      logic [SIZE_W-1:0] excess;
   } bfa_fit_type;

endpackage

### src/bfa_fit_unit.sv
module bfa_fit_unit
   import bfa_pkg::*;
(
   input logic is_free,
   input logic [SIZE_W-1:0] size,
   input logic [SIZE_W-1:0] want,
   input logic found,
   input logic [SIZE_W-1:0] best,
   output bfa_fit_type fit
);

   logic [SIZE_W:0] diff;

   // borrow out of the subtract means the block is too small
   assign diff = {1'b0, size} - {1'b0, want};

   always_comb begin
      fit.excess = diff[SIZE_W-1:0];
      fit.take = is_free && !diff[SIZE_W] && (!found || (diff[SIZE_W-1:0] < best));
   end

endmodule

### src/bfa_seq.sv
module bfa_seq
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
   input logic clock,
   input logic reset,
   input logic start,
   input bfa_req_type req_data,
   input logic [BASE_W-1:0] base_size,
   output logic busy,
   output logic rsp_valid,
   output bfa_rsp_type rsp_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic [NUM_BLOCKS-1:0] free_mask_ff, free_mask_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] want_ff, want_in;
   logic found_ff, found_in;
   logic [SIZE_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic rsp_valid_ff, rsp_valid_in;
   bfa_rsp_type rsp_ff, rsp_in;

   logic cur_free;
   bfa_fit_type fit;

   always_comb begin
      cur_free = 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            cur_free = free_mask_ff[i];
         end
      end
   end

   bfa_fit_unit u_fit (
      .is_free(cur_free),
      .size(size_ff),
      .want(want_ff),
      .found(found_ff),
      .best(best_ff),
      .fit(fit)
   );

   always_comb begin
      state_in = state_ff;
      free_mask_in = free_mask_ff;
      idx_in = idx_ff;
      size_in = size_ff;
      want_in = want_ff;
      found_in = found_ff;
      best_in = best_ff;
      pick_in = pick_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.req_type == REQ_ALLOC) begin
                  state_in = S_SCAN;
                  idx_in = '0;
                  size_in = SIZE_W'(base_size);
                  want_in = req_data.request_size;
                  found_in = 1'b0;
                  best_in = '0;
                  pick_in = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_UNKNOWN;
                  rsp_in.result_id = '0;
                  for (int i = 0; i < NUM_BLOCKS; i++) begin
                     if (req_data.block_id == ID_W'(i + 1)) begin
                        free_mask_in[i] = 1'b1;
                        rsp_in.status = ST_FREED;
                        rsp_in.result_id = req_data.block_id;
                     end
                  end
               end
            end
         end
         S_SCAN: begin
            if (fit.take) begin
               found_in = 1'b1;
               best_in = fit.excess;
               pick_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            size_in = {size_ff[SIZE_W-2:0], 1'b0};
            if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (found_in) begin
                  rsp_in.status = ST_ALLOCATED;
                  rsp_in.result_id = ID_W'(pick_in) + 1'b1;
                  for (int i = 0; i < NUM_BLOCKS; i++) begin
                     if (pick_in == IDX_W'(i)) begin
                        free_mask_in[i] = 1'b0;
                     end
                  end
               end else begin
                  rsp_in.status = ST_NOFIT;
                  rsp_in.result_id = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_mask_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_mask_ff <= free_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      size_ff <= size_in;
      want_ff <= want_in;
      found_ff <= found_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### src/best_fit_block_allocator.sv
// channel   | ports                      | direction | transaction
// ----------+----------------------------+-----------+---------------------------------
// request   | start, busy, req_data      | in        | start high while busy is low
// response  | rsp_valid, rsp_data        | out       | one-cycle strobe, always taken
// csr       | csr_we, csr_wdata          | in        | base block size, written on csr_we
//
// an allocate scans the blocks one per cycle through a single fit unit:
// busy is raised for the whole scan and the response is registered after the last block
// a free is answered the cycle after accept and never raises busy
// synchronous active-high reset: all blocks free, base size 512
// the response strobe cannot be held off; a new transaction may be accepted
// in the same cycle a response is shown
module best_fit_block_allocator
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input bfa_req_type req_data,
   output logic rsp_valid,
   output bfa_rsp_type rsp_data,
   input logic csr_we,
   input logic [BASE_W-1:0] csr_wdata
);

   // size of block zero; block i is this shifted left by i
   logic [BASE_W-1:0] base_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff <= BASE_RESET;
      end else if (csr_we) begin
         base_size_ff <= csr_wdata;
      end
   end

   // sequencer, free mask and shared fit unit
   bfa_seq #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .base_size(base_size_ff),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule

### sim/bfa_alloc_checker.sv
module bfa_alloc_checker
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input bfa_req_type req_data,
   input logic rsp_valid,
   input bfa_rsp_type rsp_data,
   input logic csr_we,
   input logic [BASE_W-1:0] csr_wdata,
   output int fail_count,
   output int outstanding,
   output int checked_count,
   output int grant_count,
   output int nofit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the allocator state
   logic [BASE_W-1:0] base_size;
   logic [MAX_BLOCKS-1:0] free_blocks;
   bfa_rsp_type owed_answers[$];

   int n_fail = 0;
   int n_checked = 0;
   int n_grant = 0;
   int n_nofit = 0;

   assign fail_count = n_fail;
   assign outstanding = owed_answers.size();
   assign checked_count = n_checked;
   assign grant_count = n_grant;
   assign nofit_count = n_nofit;

   task automatic report_mismatch(input string msg);
      if (n_fail < 40) begin
         $display("[%0t] ERROR %s", $realtime, msg);
      end
      n_fail++;
   endtask

   // best fit: smallest excess among free blocks that hold the size, lowest index on ties
   function automatic bfa_rsp_type serve_request(input bfa_req_type r);
      bfa_rsp_type rsp;
      logic found;
      int unsigned pick;
      logic [31:0] blk;
      logic [31:0] waste;
      logic [31:0] best;
      found = 1'b0;
      pick = 0;
      best = '0;
      rsp.status = ST_NOFIT;
      rsp.result_id = '0;
      if (r.req_type == REQ_ALLOC) begin
         for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk = 32'(base_size) << i;
            if (free_blocks[i] && blk >= 32'(r.request_size)) begin
               waste = blk - 32'(r.request_size);
               if (!found || waste < best) begin
                  found = 1'b1;
                  best = waste;
                  pick = i;
               end
            end
         end
         if (found) begin
            free_blocks[pick] = 1'b0;
            rsp.status = ST_ALLOCATED;
            rsp.result_id = ID_W'(pick + 1);
         end
      end else if (r.block_id >= 1 && r.block_id <= NUM_BLOCKS) begin
         free_blocks[r.block_id - 1] = 1'b1;
         rsp.status = ST_FREED;
         rsp.result_id = r.block_id;
      end else begin
         rsp.status = ST_UNKNOWN;
      end
      return rsp;
   endfunction

   always @(posedge clock) begin
      bfa_rsp_type want;
      if (reset) begin
         base_size = BASE_RESET;
         free_blocks = '1;
         owed_answers.delete();
      end else begin
         if (rsp_valid) begin
            if (owed_answers.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0d with nothing expected",
                  rsp_data.status, rsp_data.result_id));
            end else begin
               want = owed_answers.pop_front();
               n_checked++;
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status got %0d want %0d",
                     rsp_data.status, want.status));
               end
               if (rsp_data.result_id !== want.result_id) begin
                  report_mismatch($sformatf("result_id got %0d want %0d",
                     rsp_data.result_id, want.result_id));
               end
               if (want.status == ST_ALLOCATED) n_grant++;
               if (want.status == ST_NOFIT) n_nofit++;
            end
         end
         if (start && !busy) begin
            owed_answers.push_back(serve_request(req_data));
         end
         if (csr_we) begin
            base_size = csr_wdata;
         end
      end
   end

endmodule

### sim/tb_top.sv
module tb_top;
   import bfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BLOCKS = DEF_NUM_BLOCKS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 100;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   bfa_req_type req_data;
   logic rsp_valid;
   bfa_rsp_type rsp_data;
   logic csr_we;
   logic [BASE_W-1:0] csr_wdata;

   int fail_count;
   int outstanding;
   int checked_count;
   int grant_count;
   int nofit_count;

   // stimulus bookkeeping
   int cycle_count = 0;
   int items_sent = 0;
   int base_writes = 0;
   bit idle_on = 1'b0;
   logic [BASE_W-1:0] cur_base = BASE_RESET;

   best_fit_block_allocator #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // predicts every response and compares it in order
   bfa_alloc_checker #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .checked_count(checked_count),
      .grant_count(grant_count),
      .nofit_count(nofit_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("best_fit_block_allocator: mismatch");
         $finish;
      end
   end

   // present one transaction, hold it until the block takes it, then maybe idle
   task automatic post_request(input bfa_req_type r);
      int gap;
      int roll;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
      gap = 0;
      if (idle_on) begin
         roll = $urandom_range(0, 99);
         // mostly back to back, some short gaps, a few long ones
         if (roll >= 95) gap = $urandom_range(10, 40);
         else if (roll >= 65) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic ask_alloc(input logic [SIZE_W-1:0] size);
      bfa_req_type r;
      r.req_type = REQ_ALLOC;
      r.request_size = size;
      r.block_id = ID_W'($urandom);
      post_request(r);
   endtask

   task automatic ask_free(input logic [ID_W-1:0] id);
      bfa_req_type r;
      r.req_type = REQ_FREE;
      r.request_size = SIZE_W'($urandom);
      r.block_id = id;
      post_request(r);
   endtask

   // hold off until every response is back, plus the scan latency
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
      repeat (NUM_BLOCKS + 2) @(posedge clock);
   endtask

   // base size only changes while nothing is in flight
   task automatic write_base(input logic [BASE_W-1:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_base = v;
      base_writes++;
   endtask

   // sizes cluster around block boundaries so exact fits and near misses are common
   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      int k;
      int s;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         k = $urandom_range(0, NUM_BLOCKS - 1);
         s = (int'(cur_base) << k) + int'($urandom_range(0, 4)) - 2;
         if (s < 0) s = 0;
      end else if (roll < 70) begin
         s = 0;
      end else if (roll < 82) begin
         s = $urandom_range(0, int'(cur_base) << (NUM_BLOCKS - 1));
      end else begin
         s = int'($urandom_range(0, (1 << SIZE_W) - 1));
      end
      return SIZE_W'(s);
   endfunction

   initial begin
      logic [BASE_W-1:0] phase_base[8];
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset base, blocks of 512/1024/2048/4096
      ask_alloc('0);                 // zero size takes the smallest free block
      ask_alloc(SIZE_W'(4096));      // exact fit on the largest
      ask_alloc(SIZE_W'(4097));      // larger than any block
      ask_alloc('1);                 // widest request
      ask_alloc(SIZE_W'(600));       // best fit is the 1024 block
      ask_alloc(SIZE_W'(1));         // only one block left
      ask_alloc('0);                 // everything in use
      ask_free(ID_W'(0));            // id zero is unknown
      ask_free(ID_W'(NUM_BLOCKS + 1));
      ask_free('1);
      ask_free(ID_W'(2));
      ask_free(ID_W'(2));            // freeing a free block is harmless
      ask_free(ID_W'(1));
      ask_free(ID_W'(3));
      ask_free(ID_W'(4));

      // zero base: every block has size zero, ties go to the lowest index
      write_base('0);
      repeat (NUM_BLOCKS + 1) ask_alloc('0);
      ask_alloc(SIZE_W'(1));
      ask_free(ID_W'(3));
      ask_alloc('0);

      // largest base
      write_base('1);
      ask_alloc(SIZE_W'(65535 << (NUM_BLOCKS - 1)));
      ask_alloc(SIZE_W'((65535 << (NUM_BLOCKS - 1)) + 1));
      for (int i = 1; i <= NUM_BLOCKS; i++) ask_free(ID_W'(i));

      // random phases, each with its own base size
      phase_base = '{16'd1, 16'd65535, 16'd0, 16'd3, BASE_RESET,
                     BASE_W'($urandom_range(2, 65534)),
                     BASE_W'($urandom_range(2, 65534)), 16'd65535};
      for (int p = 0; p < 8; p++) begin
         write_base(phase_base[p]);
         // every third phase runs with no idling at all
         idle_on = (p % 3) != 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 55) begin
               ask_alloc(pick_size());
            end else if ($urandom_range(0, 99) < 85) begin
               ask_free(ID_W'($urandom_range(1, NUM_BLOCKS)));
            end else begin
               ask_free(ID_W'($urandom));
            end
            if ($urandom_range(0, 99) < 2) wait_idle();
         end
      end

      // drain everything, with a margin for a late stray strobe
      wait_idle();
      repeat (NUM_BLOCKS + 8) @(negedge clock);

      $display("covered %0d transactions under %0d base size writes", items_sent, base_writes);
      $display("%0d responses checked: %0d grants, %0d with no fitting block",
         checked_count, grant_count, nofit_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("best_fit_block_allocator: match");
      end else begin
         $display("best_fit_block_allocator: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
src/bfa_pkg.sv
src/bfa_fit_unit.sv
src/bfa_seq.sv
src/best_fit_block_allocator.sv
sim/bfa_alloc_checker.sv
sim/tb_top.sv
